/* src/nsp_pkg.sv */
// nsp_pkg: shared types and constants for the nearest segment search
// used by nsp_front, nsp_back and nearest_segment_to_point
package nsp_pkg;

    localparam int MAX_SEGMENTS_DEF = 8192;
    localparam int QUEUE_DEPTH      = 4;
    localparam int DIV_STEPS        = 50;   // quotient is at most |v|^2 < 2^50
    localparam int IDX_OUT_W        = 13;

    localparam logic [1:0] REG_QUERY_X = 2'd0;
    localparam logic [1:0] REG_QUERY_Y = 2'd1;
    localparam logic [1:0] REG_RADIUS  = 2'd2;

    // classified segment handed from front to back
    typedef struct packed {
        logic               hit;
        logic               last;
        logic signed [24:0] vx;
        logic signed [24:0] vy;
        logic signed [24:0] wx;
        logic signed [24:0] wy;
        logic signed [16:0] dx;
        logic signed [16:0] dy;
    } nsp_entry_t;

    typedef enum logic [3:0] {
        B_IDLE,
        B_MUL,
        B_SUM,
        B_CLS,
        B_TMUL,
        B_TSUM,
        B_DIV,
        B_SUB,
        B_CMP,
        B_OUT
    } nsp_state_t;

endpackage

/* src/nsp_fifo.sv */
// nsp_fifo: small register queue between front and back
// generic width and depth, no package dependency
module nsp_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    input  logic             pop,
    output logic [WIDTH-1:0] pop_data,
    output logic             full,
    output logic             empty
);
    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [PW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]    count_reg, count_next;

    assign full     = (count_reg == CW'(DEPTH));
    assign empty    = (count_reg == '0);
    assign pop_data = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

    a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !full) else $error("push into full queue");
    a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !empty) else $error("pop from empty queue");
    a_count_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (push == pop) |=> $stable(count_reg)) else $error("queue count drift");

endmodule

/* src/nsp_front.sv */
// nsp_front: accepts segments, numbers them, tests the grown box
// and forms the difference vectors; depends on nsp_pkg
module nsp_front #(
    parameter int MAX_SEGMENTS = nsp_pkg::MAX_SEGMENTS_DEF,
    parameter int IDX_W        = $clog2(MAX_SEGMENTS)
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic signed [15:0]  start_x,
    input  logic signed [15:0]  start_y,
    input  logic signed [15:0]  end_x,
    input  logic signed [15:0]  end_y,
    input  logic                last,
    input  logic signed [23:0]  query_x,
    input  logic signed [23:0]  query_y,
    input  logic [22:0]         search_radius,
    input  logic                queue_full,
    output logic                push,
    output nsp_pkg::nsp_entry_t push_entry,
    output logic [IDX_W-1:0]    push_index
);
    import nsp_pkg::*;

    logic [IDX_W-1:0]   count_reg, count_next;
    logic signed [25:0] sx, sy, ex, ey, qx, qy, r;
    logic signed [25:0] lox, hix, loy, hiy;
    logic               in_box;

    assign in_ready = !queue_full;
    assign push     = in_valid && !queue_full;

    always_comb
    begin
        sx = 26'({start_x, 8'b0});
        sy = 26'({start_y, 8'b0});
        ex = 26'({end_x, 8'b0});
        ey = 26'({end_y, 8'b0});
        sx = $signed({{2{start_x[15]}}, start_x, 8'b0});
        sy = $signed({{2{start_y[15]}}, start_y, 8'b0});
        ex = $signed({{2{end_x[15]}}, end_x, 8'b0});
        ey = $signed({{2{end_y[15]}}, end_y, 8'b0});
        qx = 26'(query_x);
        qy = 26'(query_y);
        r  = $signed({3'b0, search_radius});
        lox = ((sx < ex) ? sx : ex) - r;
        hix = ((sx < ex) ? ex : sx) + r;
        loy = ((sy < ey) ? sy : ey) - r;
        hiy = ((sy < ey) ? ey : sy) + r;
        in_box = (qx >= lox) && (qx <= hix) && (qy >= loy) && (qy <= hiy);

        push_entry.hit  = in_box;
        push_entry.last = last;
        push_entry.vx   = 25'(qx - sx);
        push_entry.vy   = 25'(qy - sy);
        push_entry.wx   = 25'(qx - ex);
        push_entry.wy   = 25'(qy - ey);
        push_entry.dx   = 17'(end_x) - 17'(start_x);
        push_entry.dy   = 17'(end_y) - 17'(start_y);
        push_index      = count_reg;

        count_next = count_reg;
        if (push)
        begin
            if (last || count_reg == IDX_W'(MAX_SEGMENTS - 1))
            begin
                count_next = '0;
            end
            else
            begin
                count_next = count_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

endmodule

/* src/nsp_back.sv */
// nsp_back: distance sequencer with multipliers and a radix-2
// divider, keeps the best match and holds the result; depends on nsp_pkg
module nsp_back #(
    parameter int IDX_W = 13
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                queue_empty,
    output logic                pop,
    input  nsp_pkg::nsp_entry_t pop_entry,
    input  logic [IDX_W-1:0]    pop_index,
    input  logic [22:0]         search_radius,
    output logic                out_valid,
    input  logic                out_ready,
    output logic                found,
    output logic [12:0]         closest_index
);
    import nsp_pkg::*;

    localparam int CNT_W = $clog2(DIV_STEPS);

    nsp_state_t         state_reg, state_next;
    logic               have_reg, have_next;
    logic               ovalid_reg, ovalid_next;

    nsp_entry_t         ent_reg, ent_next;
    logic [IDX_W-1:0]   idx_reg, idx_next;
    logic [IDX_W-1:0]   best_idx_reg, best_idx_next;
    logic [49:0]        best_reg, best_next;
    logic signed [49:0] pvx_reg, pvx_next, pvy_reg, pvy_next;
    logic signed [49:0] pwx_reg, pwx_next, pwy_reg, pwy_next;
    logic signed [33:0] pdx_reg, pdx_next, pdy_reg, pdy_next;
    logic signed [41:0] ptx_reg, ptx_next, pty_reg, pty_next;
    logic [45:0]        rsq_reg, rsq_next;
    logic [49:0]        vsq_reg, vsq_next, wsq_reg, wsq_next;
    logic [33:0]        len_reg, len_next;
    logic signed [42:0] t_reg, t_next;
    logic [41:0]        hh_reg, hh_next, hl_reg, hl_next, ll_reg, ll_next;
    logic [33:0]        rem_reg, rem_next;
    logic [49:0]        dvd_reg, dvd_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic [49:0]        dist_reg, dist_next;
    logic               found_reg, found_next;
    logic [12:0]        cidx_reg, cidx_next;

    logic [41:0]        tu;
    logic [83:0]        sq;
    logic [34:0]        trial;
    logic               ge;
    logic [49:0]        thr;
    logic               slot_free;

    assign out_valid     = ovalid_reg;
    assign found         = found_reg;
    assign closest_index = cidx_reg;
    assign slot_free     = !ovalid_reg || out_ready;

    always_comb
    begin
        state_next    = state_reg;
        have_next     = have_reg;
        ovalid_next   = ovalid_reg && !out_ready;
        ent_next      = ent_reg;
        idx_next      = idx_reg;
        best_idx_next = best_idx_reg;
        best_next     = best_reg;
        pvx_next = pvx_reg; pvy_next = pvy_reg;
        pwx_next = pwx_reg; pwy_next = pwy_reg;
        pdx_next = pdx_reg; pdy_next = pdy_reg;
        ptx_next = ptx_reg; pty_next = pty_reg;
        rsq_next = rsq_reg;
        vsq_next = vsq_reg; wsq_next = wsq_reg;
        len_next = len_reg; t_next = t_reg;
        hh_next  = hh_reg; hl_next = hl_reg; ll_next = ll_reg;
        rem_next = rem_reg; dvd_next = dvd_reg; cnt_next = cnt_reg;
        dist_next  = dist_reg;
        found_next = found_reg;
        cidx_next  = cidx_reg;
        pop = 1'b0;

        tu    = t_reg[41:0];
        sq    = {hh_reg, 42'b0} + 84'({hl_reg, 22'b0}) + 84'(ll_reg);
        trial = {rem_reg, dvd_reg[49]};
        ge    = (trial >= {1'b0, len_reg});
        thr   = have_reg ? best_reg : 50'(rsq_reg);

        case (state_reg)
            B_IDLE:
            begin
                if (!queue_empty)
                begin
                    pop        = 1'b1;
                    ent_next   = pop_entry;
                    idx_next   = pop_index;
                    state_next = pop_entry.hit ? B_MUL : B_CMP;
                end
            end
            B_MUL:
            begin
                pvx_next = ent_reg.vx * ent_reg.vx;
                pvy_next = ent_reg.vy * ent_reg.vy;
                pwx_next = ent_reg.wx * ent_reg.wx;
                pwy_next = ent_reg.wy * ent_reg.wy;
                pdx_next = ent_reg.dx * ent_reg.dx;
                pdy_next = ent_reg.dy * ent_reg.dy;
                ptx_next = ent_reg.vx * ent_reg.dx;
                pty_next = ent_reg.vy * ent_reg.dy;
                rsq_next = search_radius * search_radius;
                state_next = B_SUM;
            end
            B_SUM:
            begin
                vsq_next = $unsigned(pvx_reg) + $unsigned(pvy_reg);
                wsq_next = $unsigned(pwx_reg) + $unsigned(pwy_reg);
                len_next = $unsigned(pdx_reg) + $unsigned(pdy_reg);
                t_next   = 43'(ptx_reg) + 43'(pty_reg);
                state_next = B_SUM == B_SUM ? B_CLS : B_CLS;
            end
            B_CLS:
            begin
                // degenerate segment or projection before the start point
                if (len_reg == '0 || t_reg[42])
                begin
                    dist_next  = vsq_reg;
                    state_next = B_CMP;
                end
                // projection past the end point
                else if (tu > {len_reg, 8'b0})
                begin
                    dist_next  = wsq_reg;
                    state_next = B_CMP;
                end
                else
                begin
                    state_next = B_TMUL;
                end
            end
            B_TMUL:
            begin
                hh_next = tu[41:21] * tu[41:21];
                hl_next = tu[41:21] * tu[20:0];
                ll_next = tu[20:0] * tu[20:0];
                state_next = B_TSUM;
            end
            B_TSUM:
            begin
                rem_next   = sq[83:50];
                dvd_next   = sq[49:0];
                cnt_next   = '0;
                state_next = B_DIV;
            end
            B_DIV:
            begin
                rem_next = ge ? 34'(trial - {1'b0, len_reg}) : trial[33:0];
                dvd_next = {dvd_reg[48:0], ge};
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(DIV_STEPS - 1))
                begin
                    state_next = B_SUB;
                end
            end
            B_SUB:
            begin
                dist_next  = vsq_reg - dvd_reg;
                state_next = B_CMP;
            end
            B_CMP:
            begin
                if (ent_reg.hit && dist_reg <= thr)
                begin
                    best_next     = dist_reg;
                    best_idx_next = idx_reg;
                    have_next     = 1'b1;
                end
                state_next = ent_reg.last ? B_OUT : B_IDLE;
            end
            B_OUT:
            begin
                if (slot_free)
                begin
                    ovalid_next = 1'b1;
                    found_next  = have_reg;
                    cidx_next   = have_reg ? 13'(best_idx_reg) : '0;
                    have_next   = 1'b0;
                    state_next  = B_IDLE;
                end
            end
            default:
            begin
                state_next = B_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= B_IDLE;
            have_reg   <= 1'b0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            have_reg   <= have_next;
            ovalid_reg <= ovalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ent_reg <= ent_next; idx_reg <= idx_next;
        best_idx_reg <= best_idx_next; best_reg <= best_next;
        pvx_reg <= pvx_next; pvy_reg <= pvy_next;
        pwx_reg <= pwx_next; pwy_reg <= pwy_next;
        pdx_reg <= pdx_next; pdy_reg <= pdy_next;
        ptx_reg <= ptx_next; pty_reg <= pty_next;
        rsq_reg <= rsq_next;
        vsq_reg <= vsq_next; wsq_reg <= wsq_next;
        len_reg <= len_next; t_reg <= t_next;
        hh_reg <= hh_next; hl_reg <= hl_next; ll_reg <= ll_next;
        rem_reg <= rem_next; dvd_reg <= dvd_next; cnt_reg <= cnt_next;
        dist_reg <= dist_next;
        found_reg <= found_next; cidx_reg <= cidx_next;
    end

    a_rem_below_len: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == B_DIV) |-> (rem_reg < len_reg))
        else $error("divider remainder not below divisor");
    a_pop_idle: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> (state_reg == B_IDLE && !queue_empty))
        else $error("pop outside idle");
    a_result_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == B_OUT && slot_free) |=> (ovalid_reg && !have_reg))
        else $error("result not posted or match not cleared");
    a_not_found_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (ovalid_reg && !found_reg) |-> (cidx_reg == '0))
        else $error("index set without a match");

endmodule

/* src/nearest_segment_to_point.sv */
// nearest_segment_to_point: top level, configuration registers and
// front / queue / back hookup; depends on nsp_pkg, nsp_front, nsp_fifo, nsp_back
//
// channel   | handshake          | payload
// ----------+--------------------+------------------------------------------
// in        | in_valid/in_ready  | start_x start_y end_x end_y last
// out       | out_valid/out_ready| found closest_index
// cfg       | cfg_we (no wait)   | cfg_index cfg_data
//
// back sequencer states per segment: IDLE and CMP when the grown box misses the
// query; IDLE, MUL, SUM, CLS and CMP when the nearest point is an endpoint; with
// TMUL, TSUM, the one-bit-per-cycle divider DIV and SUB added when the projection
// lands inside; the request carrying last also passes OUT to post the result
// the front takes a request each cycle while the 4-entry queue has room, so
// a stalled output only stops input once the queue fills
// reset clears the search state, the queue and the configuration to zero
module nearest_segment_to_point #(
    parameter int MAX_SEGMENTS = nsp_pkg::MAX_SEGMENTS_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic signed [15:0] start_x,
    input  logic signed [15:0] start_y,
    input  logic signed [15:0] end_x,
    input  logic signed [15:0] end_y,
    input  logic               last,
    output logic               out_valid,
    input  logic               out_ready,
    output logic               found,
    output logic [12:0]        closest_index,
    input  logic               cfg_we,
    input  logic [1:0]         cfg_index,
    input  logic [23:0]        cfg_data
);
    import nsp_pkg::*;

    localparam int IDX_W = $clog2(MAX_SEGMENTS);
    localparam int QW    = $bits(nsp_entry_t) + IDX_W;

    // query point and radius; the user must write them only while idle, the block does not enforce it
    logic signed [23:0] qx_reg;
    logic signed [23:0] qy_reg;
    logic [22:0]        radius_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            qx_reg     <= '0;
            qy_reg     <= '0;
            radius_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_QUERY_X: qx_reg     <= cfg_data;
                REG_QUERY_Y: qy_reg     <= cfg_data;
                REG_RADIUS:  radius_reg <= cfg_data[22:0];
                default:     ;  // unknown index, write dropped
            endcase
        end
    end

    logic             push, pop, q_full, q_empty;
    nsp_entry_t       push_entry, pop_entry;
    logic [IDX_W-1:0] push_index, pop_index;
    logic [QW-1:0]    q_out;

    // front: numbering, box test, difference vectors
    nsp_front #(
        .MAX_SEGMENTS (MAX_SEGMENTS),
        .IDX_W        (IDX_W)
    ) u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .start_x       (start_x),
        .start_y       (start_y),
        .end_x         (end_x),
        .end_y         (end_y),
        .last          (last),
        .query_x       (qx_reg),
        .query_y       (qy_reg),
        .search_radius (radius_reg),
        .queue_full    (q_full),
        .push          (push),
        .push_entry    (push_entry),
        .push_index    (push_index)
    );

    // decoupling queue
    nsp_fifo #(
        .WIDTH (QW),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data ({push_entry, push_index}),
        .pop       (pop),
        .pop_data  (q_out),
        .full      (q_full),
        .empty     (q_empty)
    );

    assign pop_entry = q_out[QW-1:IDX_W];
    assign pop_index = q_out[IDX_W-1:0];

    // back: distance, best match, result register
    nsp_back #(
        .IDX_W (IDX_W)
    ) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .queue_empty   (q_empty),
        .pop           (pop),
        .pop_entry     (pop_entry),
        .pop_index     (pop_index),
        .search_radius (radius_reg),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .found         (found),
        .closest_index (closest_index)
    );

endmodule

/* tb/nearest_segment_to_point_test.sv */
// nearest_segment_to_point_test: self-checking bench for the nearest segment search
// depends on nsp_pkg and nearest_segment_to_point; segment stream against a local predictor
module nearest_segment_to_point_test;
    timeunit 1ns;
    timeprecision 1ps;
    import nsp_pkg::*;

    localparam logic [1:0] REG_UNUSED = 2'd3;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int DRAIN_CYCLES   = 300;
    localparam int SEG_WRAP       = 8192;

    typedef struct packed {
        logic        found;
        logic [12:0] index;
    } nearest_t;

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_ready;
    logic signed [15:0] start_x;
    logic signed [15:0] start_y;
    logic signed [15:0] end_x;
    logic signed [15:0] end_y;
    logic               last;
    logic               out_valid;
    logic               out_ready;
    logic               found;
    logic [12:0]        closest_index;
    logic               cfg_we;
    logic [1:0]         cfg_index;
    logic [23:0]        cfg_data;

    nearest_segment_to_point i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .start_x       (start_x),
        .start_y       (start_y),
        .end_x         (end_x),
        .end_y         (end_y),
        .last          (last),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .found         (found),
        .closest_index (closest_index),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    // predictor copy of registers and search state
    logic signed [23:0] pq_x;
    logic signed [23:0] pq_y;
    logic [22:0]        p_radius;
    logic [12:0]        p_count;
    logic [51:0]        p_best_dist;
    logic [12:0]        p_best_idx;
    logic               p_have;

    nearest_t pending_nearest[$];
    int  mismatches;
    int  idle_cycles;
    bit  no_idle;
    int  ready_hold;
    bit  ready_state;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // squared distance from query to segment, Q.16, exact
    function automatic logic [51:0] seg_dist_sq(input logic signed [15:0] ax,
                                                input logic signed [15:0] ay,
                                                input logic signed [15:0] bx,
                                                input logic signed [15:0] by);
        longint sx, sy, ex, ey, vx, vy, wx, wy, dx, dy, vsq, wsq, len, t;
        logic [127:0] tt;
        logic [127:0] quo;
        sx = longint'(ax) * 256;
        sy = longint'(ay) * 256;
        ex = longint'(bx) * 256;
        ey = longint'(by) * 256;
        vx = longint'(pq_x) - sx;
        vy = longint'(pq_y) - sy;
        wx = longint'(pq_x) - ex;
        wy = longint'(pq_y) - ey;
        dx = longint'(bx) - longint'(ax);
        dy = longint'(by) - longint'(ay);
        vsq = vx * vx + vy * vy;
        wsq = wx * wx + wy * wy;
        len = dx * dx + dy * dy;
        t = vx * dx + vy * dy;
        if (len == 0 || t < 0)
            return vsq[51:0];
        if (t > len * 256)
            return wsq[51:0];
        tt = {64'd0, t} * {64'd0, t};
        quo = tt / {64'd0, len};
        return vsq[51:0] - quo[51:0];
    endfunction

    // one accepted segment; returns 1 when it closes a search
    function automatic bit track_nearest(input logic signed [15:0] ax,
                                         input logic signed [15:0] ay,
                                         input logic signed [15:0] bx,
                                         input logic signed [15:0] by,
                                         input logic lst, output nearest_t res);
        longint r, lox, hix, loy, hiy, qx, qy;
        logic [51:0] d, thr;
        r = longint'(p_radius);
        qx = longint'(pq_x);
        qy = longint'(pq_y);
        lox = (ax < bx ? longint'(ax) : longint'(bx)) * 256 - r;
        hix = (ax < bx ? longint'(bx) : longint'(ax)) * 256 + r;
        loy = (ay < by ? longint'(ay) : longint'(by)) * 256 - r;
        hiy = (ay < by ? longint'(by) : longint'(ay)) * 256 + r;
        if (qx >= lox && qx <= hix && qy >= loy && qy <= hiy)
        begin
            d = seg_dist_sq(ax, ay, bx, by);
            thr = p_have ? p_best_dist : 52'(r * r);
            if (d <= thr)
            begin
                p_best_dist = d;
                p_best_idx = p_count;
                p_have = 1'b1;
            end
        end
        p_count = (int'(p_count) + 1 >= SEG_WRAP) ? 13'd0 : p_count + 13'd1;
        res = '0;
        if (!lst)
            return 1'b0;
        res.found = p_have;
        res.index = p_have ? p_best_idx : 13'd0;
        p_count = '0;
        p_best_dist = '0;
        p_best_idx = '0;
        p_have = 1'b0;
        return 1'b1;
    endfunction

    // request driver, with random gaps unless the run is in its no-idle tail
    task automatic send_segment(input logic signed [15:0] ax, input logic signed [15:0] ay,
                                input logic signed [15:0] bx, input logic signed [15:0] by,
                                input logic lst);
        nearest_t res;
        if (!no_idle && $urandom_range(0, 3) == 0)
        begin
            in_valid = 1'b0;
            repeat ($urandom_range(1, 8)) @(negedge clk);
        end
        start_x = ax;
        start_y = ay;
        end_x = bx;
        end_y = by;
        last = lst;
        in_valid = 1'b1;
        do
            @(posedge clk);
        while (!in_ready);
        if (track_nearest(ax, ay, bx, by, lst, res))
            pending_nearest.push_back(res);
        @(negedge clk);
    endtask

    // wait for every result, then let the back end settle before register writes
    task automatic wait_idle();
        in_valid = 1'b0;
        while (pending_nearest.size() != 0)
            @(negedge clk);
        repeat (80) @(negedge clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [23:0] data);
        cfg_we = 1'b1;
        cfg_index = idx;
        cfg_data = data;
        @(negedge clk);
        cfg_we = 1'b0;
        case (idx)
            REG_QUERY_X: pq_x = data;
            REG_QUERY_Y: pq_y = data;
            REG_RADIUS:  p_radius = data[22:0];
            default: ;
        endcase
    endtask

    // endpoint near the query most of the time so the distance path is exercised
    function automatic logic signed [15:0] near_coord(input logic signed [23:0] q);
        longint c;
        if ($urandom_range(0, 3) == 0)
            return 16'($urandom);
        c = (longint'(q) >>> 8) + longint'($urandom_range(0, 24)) - 12;
        if (c > 32767)
            c = 32767;
        if (c < -32768)
            c = -32768;
        return 16'(c);
    endfunction

    task automatic send_near(input logic lst);
        send_segment(near_coord(pq_x), near_coord(pq_y),
                     near_coord(pq_x), near_coord(pq_y), lst);
    endtask

    task automatic test_directed();
        write_reg(REG_QUERY_X, 24'sd0);
        write_reg(REG_QUERY_Y, 24'sd0);
        write_reg(REG_RADIUS, 24'd0);
        // zero-length segment on the query with zero radius, then a tie later
        send_segment(0, 0, 0, 0, 1'b0);
        send_segment(0, 0, 0, 0, 1'b1);
        wait_idle();
        write_reg(REG_QUERY_X, 24'sd640);
        write_reg(REG_QUERY_Y, 24'sd128);
        write_reg(REG_RADIUS, 24'd1024);
        // projection inside, before start, past end, miss, zero length
        send_segment(0, 0, 10, 0, 1'b0);
        send_segment(3, 0, 9, 3, 1'b0);
        send_segment(-3, -1, 1, 1, 1'b0);
        send_segment(40, 40, 50, 50, 1'b0);
        send_segment(2, 1, 2, 1, 1'b0);
        send_segment(1, 0, 4, 0, 1'b1);
        // search with nothing inside the radius
        send_segment(100, 100, 200, 200, 1'b1);
        wait_idle();
        // unused register index must be ignored
        write_reg(REG_UNUSED, 24'hffffff);
        write_reg(REG_QUERY_X, 24'h7fffff);
        write_reg(REG_QUERY_Y, 24'h800000);
        write_reg(REG_RADIUS, 24'h7fffff);
        send_segment(32767, -32768, 32767, -32768, 1'b0);
        send_segment(-32768, 32767, 32767, -32768, 1'b0);
        send_segment(-32768, -32768, -32768, 32767, 1'b0);
        send_segment(32767, 32767, -32768, -32768, 1'b1);
        wait_idle();
        write_reg(REG_QUERY_X, 24'h800000);
        write_reg(REG_QUERY_Y, 24'h7fffff);
        send_segment(-32768, 32767, -32768, 32767, 1'b0);
        send_segment(-32768, -32768, 32767, 32767, 1'b1);
        wait_idle();
    endtask

    task automatic test_random();
        int sent;
        int len;
        sent = 0;
        while (sent < 760)
        begin
            if ($urandom_range(0, 1))
            begin
                write_reg(REG_QUERY_X, $urandom_range(0, 1) ? 24'($urandom)
                                                           : 24'($urandom_range(0, 8191)) - 24'd4096);
                write_reg(REG_QUERY_Y, $urandom_range(0, 1) ? 24'($urandom)
                                                           : 24'($urandom_range(0, 8191)) - 24'd4096);
            end
            case ($urandom_range(0, 4))
                0: write_reg(REG_RADIUS, 24'd0);
                1: write_reg(REG_RADIUS, 24'h7fffff);
                2: write_reg(REG_RADIUS, 24'($urandom) & 24'h7fffff);
                default: write_reg(REG_RADIUS, 24'($urandom_range(0, 6000)));
            endcase
            no_idle = (sent > 600);
            len = $urandom_range(1, 20);
            for (int i = 0; i < len; i++)
                send_near(i == len - 1);
            sent += len;
            wait_idle();
        end
        no_idle = 1'b0;
    endtask

    // random output stalls in bursts; always ready in the tail
    always @(negedge clk)
    begin
        if (ready_hold > 0)
            ready_hold <= ready_hold - 1;
        else if (no_idle)
            ready_state <= 1'b1;
        else
        begin
            ready_state <= $urandom_range(0, 2) != 0;
            ready_hold <= $urandom_range(1, 8);
        end
    end
    assign out_ready = ready_state;

    // result checker and watchdog
    always @(posedge clk)
    begin
        nearest_t exp_r;
        if (rst_n)
        begin
            if ((in_valid && in_ready) || (out_valid && out_ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (out_valid && out_ready)
            begin
                if (pending_nearest.size() == 0)
                begin
                    mismatches = mismatches + 1;
                    if (mismatches <= 10)
                        $display("unexpected result found=%0b index=%0d", found, closest_index);
                end
                else
                begin
                    exp_r = pending_nearest.pop_front();
                    if (found !== exp_r.found || closest_index !== exp_r.index)
                    begin
                        mismatches = mismatches + 1;
                        if (mismatches <= 10)
                            $display("mismatch: expected found=%0b index=%0d, got found=%0b index=%0d",
                                     exp_r.found, exp_r.index, found, closest_index);
                    end
                end
            end
        end
    end

    initial
    begin
        wait (idle_cycles >= WATCHDOG_LIMIT);
        $display("nearest_segment_to_point_test: FAIL");
        $finish;
    end

    initial
    begin
        rst_n = 1'b0;
        in_valid = 1'b0;
        start_x = '0;
        start_y = '0;
        end_x = '0;
        end_y = '0;
        last = 1'b0;
        cfg_we = 1'b0;
        cfg_index = REG_QUERY_X;
        cfg_data = '0;
        ready_state = 1'b0;
        ready_hold = 0;
        no_idle = 1'b0;
        mismatches = 0;
        idle_cycles = 0;
        pq_x = '0;
        pq_y = '0;
        p_radius = '0;
        p_count = '0;
        p_best_dist = '0;
        p_best_idx = '0;
        p_have = 1'b0;
        repeat (9) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);
        test_directed();
        test_random();
        wait_idle();
        repeat (DRAIN_CYCLES) @(negedge clk);
        if (mismatches == 0 && pending_nearest.size() == 0)
            $display("nearest_segment_to_point_test: PASS");
        else
            $display("nearest_segment_to_point_test: FAIL");
        $finish;
    end
endmodule
